>>> hw/rtl/bilinear_image_resampler_assert.svh
// assertion macros for the bilinear resampler
`ifndef BILINEAR_IMAGE_RESAMPLER_ASSERT_SVH
`define BILINEAR_IMAGE_RESAMPLER_ASSERT_SVH

// same-cycle implication
`define BRIR_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bilinear_image_resampler: assertion failed");

// next-cycle implication
`define BRIR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bilinear_image_resampler: assertion failed");

`endif

>>> hw/rtl/brir_pkg.sv
// shared types and constants of the bilinear resampler
package brir_pkg;

    localparam int VAL_W       = 32;
    localparam int COORD_W     = 10;
    localparam int SRC_DIM_W   = 8;
    localparam int DST_DIM_W   = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int FRAC_W      = 16;
    localparam logic [FRAC_W:0] FRAC_ONE = 17'h10000;

    localparam int QDEPTH = 2;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_TOTAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_ERRORS = 3'd5;

    typedef struct packed {
        logic [SRC_DIM_W-1:0] src_width;
        logic [SRC_DIM_W-1:0] src_height;
        logic [DST_DIM_W-1:0] dst_width;
        logic [DST_DIM_W-1:0] dst_height;
        logic                 keep_total;
        logic                 use_errors;
    } t_cfg;

    typedef struct packed {
        logic                      is_cmp;
        logic                      load_ok;
        logic [COORD_W-1:0]        col;
        logic [COORD_W-1:0]        row;
        logic signed [VAL_W-1:0]   value;
        logic signed [VAL_W-1:0]   error;
    } t_item;

    typedef struct packed {
        logic [QCNT_W-1:0] fill;
    } t_front_stat;

    typedef struct packed {
        logic in_out;
        logic divx_busy;
        logic divy_busy;
    } t_back_stat;

endpackage

>>> hw/rtl/brir_req_if.sv
// request channel: load or compute words
interface brir_req_if import brir_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic [COORD_W-1:0]      col;
    logic [COORD_W-1:0]      row;
    logic signed [VAL_W-1:0] pixel_value;
    logic signed [VAL_W-1:0] pixel_error;

    modport source (output valid, req_type, col, row, pixel_value, pixel_error, input ready);
    modport sink   (input valid, req_type, col, row, pixel_value, pixel_error, output ready);
endinterface

>>> hw/rtl/brir_rsp_if.sv
// result channel: interpolated value and error
interface brir_rsp_if import brir_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] out_value;
    logic signed [VAL_W-1:0] out_error;

    modport source (output valid, out_value, out_error, input ready);
    modport sink   (input valid, out_value, out_error, output ready);
endinterface

>>> hw/rtl/bilinear_image_resampler.sv
// Bilinear resampler of one stored plane of Q23.8 values and errors. A load word
// writes one source pixel. A compute word returns one result, with area-ratio
// scaling when keep_total is set. The next word is taken in the cycle after the
// result is registered, which waits while the result register is still full. The
// coordinate dividers, one per axis at two quotient bits per cycle, and the
// area-ratio dividers, one per channel, do most of the compute work. The rest is
// four reads on the single read port of each plane store and three interpolation
// steps on one multiplier per channel. A two-word queue takes new requests while
// the back end works, and the result register holds a word until it is taken.
module bilinear_image_resampler import brir_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    brir_req_if.sink              i_req,
    brir_rsp_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_cfg        r_cfg;
    logic        w_item_valid, w_item_ready;
    t_item       w_item;
    t_front_stat w_fstat;
    t_back_stat  w_bstat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width  <= SRC_DIM_W'(128);
            r_cfg.src_height <= SRC_DIM_W'(128);
            r_cfg.dst_width  <= DST_DIM_W'(128);
            r_cfg.dst_height <= DST_DIM_W'(128);
            r_cfg.keep_total <= 1'b0;
            r_cfg.use_errors <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SRC_WIDTH:  r_cfg.src_width  <= i_cfg_data[SRC_DIM_W-1:0];
                CFG_SRC_HEIGHT: r_cfg.src_height <= i_cfg_data[SRC_DIM_W-1:0];
                CFG_DST_WIDTH:  r_cfg.dst_width  <= i_cfg_data[DST_DIM_W-1:0];
                CFG_DST_HEIGHT: r_cfg.dst_height <= i_cfg_data[DST_DIM_W-1:0];
                CFG_KEEP_TOTAL: r_cfg.keep_total <= i_cfg_data[0];
                CFG_USE_ERRORS: r_cfg.use_errors <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    brir_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_item_valid (w_item_valid),
        .i_item_ready (w_item_ready),
        .o_item       (w_item),
        .o_stat       (w_fstat)
    );

    brir_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (w_item_valid),
        .o_item_ready (w_item_ready),
        .i_item       (w_item),
        .o_rsp        (o_rsp),
        .o_stat       (w_bstat)
    );

`include "bilinear_image_resampler_assert.svh"

    `BRIR_ASSERT_IMPL(a_fill_bound, i_clk, i_rst_n, 1'b1, w_fstat.fill <= QCNT_W'(QDEPTH))
    `BRIR_ASSERT_IMPL(a_div_lockstep, i_clk, i_rst_n, 1'b1, w_bstat.divx_busy == w_bstat.divy_busy)
    `BRIR_ASSERT_IMPL(a_rsp_from_out, i_clk, i_rst_n, $rose(o_rsp.valid), $past(w_bstat.in_out))
    `BRIR_ASSERT_NEXT(a_cmp_blocks, i_clk, i_rst_n, w_item_valid && w_item_ready && w_item.is_cmp, !w_item_ready)
endmodule

>>> hw/rtl/brir_div.sv
// unsigned iterative divider, two quotient bits per cycle
module brir_div import brir_pkg::*; #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot,
    output logic [DEN_W-1:0] o_rem
);
    localparam int STEPS = NUM_W / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   t1, t2;
    logic [NUM_W-1:0] q1, q2;

    always_comb begin
        t1 = {r_rem, r_quo[NUM_W-1]};
        q1 = {r_quo[NUM_W-2:0], 1'b0};
        if (t1 >= {1'b0, r_den}) begin
            t1    = t1 - {1'b0, r_den};
            q1[0] = 1'b1;
        end
        t2 = {t1[DEN_W-1:0], q1[NUM_W-1]};
        q2 = {q1[NUM_W-2:0], 1'b0};
        if (t2 >= {1'b0, r_den}) begin
            t2    = t2 - {1'b0, r_den};
            q2[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= q2;
            r_rem <= t2[DEN_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;
endmodule

>>> hw/rtl/brir_front.sv
// front end: accepts request words, classifies them, queues them for the back end
module brir_front import brir_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    brir_req_if.sink    i_req,
    output logic        o_item_valid,
    input  logic        i_item_ready,
    output t_item       o_item,
    output t_front_stat o_stat
);
    localparam int QPW = $clog2(QDEPTH);

    t_item             r_q [QDEPTH];
    logic [QPW-1:0]    r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;

    t_item w_new;
    logic  w_push, w_pop;

    always_comb begin
        w_new.is_cmp  = (i_req.req_type == REQ_COMPUTE);
        w_new.load_ok = (32'(i_req.col) < MAX_WIDTH) && (32'(i_req.row) < MAX_HEIGHT);
        w_new.col     = i_req.col;
        w_new.row     = i_req.row;
        w_new.value   = i_req.pixel_value;
        w_new.error   = i_req.pixel_error;
    end

    assign i_req.ready  = (r_cnt != QCNT_W'(QDEPTH));
    assign w_push       = i_req.valid && i_req.ready;
    assign o_item_valid = (r_cnt != '0);
    assign w_pop        = o_item_valid && i_item_ready;
    assign o_item       = r_q[r_rp];
    assign o_stat.fill  = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (32'(r_wp) == QDEPTH - 1) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (32'(r_rp) == QDEPTH - 1) ? '0 : r_rp + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_new;
        end
    end
endmodule

>>> hw/rtl/brir_back.sv
// back end: source plane stores and the compute sequencer
module brir_back import brir_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_item_valid,
    output logic       o_item_ready,
    input  t_item      i_item,
    brir_rsp_if.source o_rsp,
    output t_back_stat o_stat
);
    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int YW     = $clog2(MAX_HEIGHT);
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int SW_MAX = (MAX_WIDTH < 255) ? MAX_WIDTH : 255;
    localparam int SH_MAX = (MAX_HEIGHT < 255) ? MAX_HEIGHT : 255;
    localparam int CN_W   = 36;
    localparam int CD_W   = 12;
    localparam int SN_W   = 52;
    localparam int SD_W   = 23;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MAP    = 4'd1;
    localparam logic [3:0] ST_DIV    = 4'd2;
    localparam logic [3:0] ST_IDX    = 4'd3;
    localparam logic [3:0] ST_RD     = 4'd4;
    localparam logic [3:0] ST_LM     = 4'd5;
    localparam logic [3:0] ST_LA     = 4'd6;
    localparam logic [3:0] ST_SMUL   = 4'd7;
    localparam logic [3:0] ST_SSTART = 4'd8;
    localparam logic [3:0] ST_SDIV   = 4'd9;
    localparam logic [3:0] ST_SFIX   = 4'd10;
    localparam logic [3:0] ST_OUT    = 4'd11;

    logic [3:0] r_state;

    // plane stores
    logic [VAL_W-1:0] r_mem_val [DEPTH];
    logic [VAL_W-1:0] r_mem_err [DEPTH];
    logic [VAL_W-1:0] r_vrd, r_erd;
    logic [AW-1:0]    w_waddr, w_raddr;
    logic             w_val_we, w_err_we;

    logic [COORD_W-1:0]   r_col, r_row;
    logic [SRC_DIM_W-1:0] r_sw, r_sh;
    logic [15:0]          r_num;
    logic [21:0]          r_den;
    logic [XW-1:0]        r_x0, r_x1;
    logic [YW-1:0]        r_y0, r_y1;
    logic [FRAC_W:0]      r_fx, r_fy;
    logic [2:0]           r_rd_cnt;
    logic [1:0]           r_step;

    logic signed [VAL_W-1:0] r_v00, r_v01, r_v10, r_v11, r_v0, r_v1, r_vres;
    logic signed [VAL_W-1:0] r_e00, r_e01, r_e10, r_e11, r_e0, r_e1, r_eres;
    logic signed [VAL_W-1:0] r_av, r_ae;
    logic signed [50:0]      r_pv, r_pe;
    logic signed [50:0]      r_snv, r_sne;
    logic                    r_vneg, r_eneg;

    logic                    r_ovld;
    logic signed [VAL_W-1:0] r_oval, r_oerr;

    // combinational helpers
    logic [SRC_DIM_W-1:0] w_sw, w_sh;
    logic [DST_DIM_W-1:0] w_dw, w_dh;
    logic [18:0]          w_px, w_py;
    logic signed [20:0]   w_nx, w_ny;
    logic [CN_W-1:0]      w_numx, w_numy;
    logic                 w_start_c, w_start_s;
    logic [CN_W-1:0]      w_qx, w_qy;
    logic [CD_W-1:0]      w_remx, w_remy;
    logic                 w_dx_busy, w_dy_busy, w_dx_done, w_dy_done;
    logic [SN_W-1:0]      w_qv, w_qe;
    logic [SD_W-1:0]      w_remv, w_reme;
    logic                 w_dv_busy, w_de_busy, w_dv_done, w_de_done;
    logic [50:0]          w_magv, w_mage;
    logic [19:0]          w_bxf, w_byf;
    logic [SRC_DIM_W-1:0] w_swm1, w_shm1;
    logic                 w_clx, w_cly;
    logic [19:0]          w_bx, w_by;
    logic [XW-1:0]        w_rx;
    logic [YW-1:0]        w_ry;
    logic signed [VAL_W-1:0] w_av, w_bv, w_ae, w_be;
    logic [FRAC_W:0]      w_f;
    logic signed [50:0]   w_sumv, w_sume;
    logic signed [VAL_W-1:0] w_lv, w_le;
    logic signed [48:0]   w_prv, w_pre;
    logic signed [VAL_W-1:0] w_satv, w_sate;

    function automatic logic signed [VAL_W-1:0] fix_sat(input logic [SN_W-1:0] q,
                                                         input logic rem_nz,
                                                         input logic neg);
        logic signed [SN_W:0] res;
        begin
            res = neg ? -$signed({1'b0, q + SN_W'(rem_nz)}) : $signed({1'b0, q});
            if (res > $signed((SN_W+1)'(32'h7fffffff))) begin
                fix_sat = 32'sh7fffffff;
            end else if (res < -$signed((SN_W+1)'(33'h080000000))) begin
                fix_sat = 32'sh80000000;
            end else begin
                fix_sat = res[VAL_W-1:0];
            end
        end
    endfunction

    always_comb begin
        w_sw = (i_cfg.src_width == '0) ? SRC_DIM_W'(1) :
               (32'(i_cfg.src_width) > SW_MAX) ? SRC_DIM_W'(SW_MAX) : i_cfg.src_width;
        w_sh = (i_cfg.src_height == '0) ? SRC_DIM_W'(1) :
               (32'(i_cfg.src_height) > SH_MAX) ? SRC_DIM_W'(SH_MAX) : i_cfg.src_height;
        w_dw = (i_cfg.dst_width == '0) ? DST_DIM_W'(1) : i_cfg.dst_width;
        w_dh = (i_cfg.dst_height == '0) ? DST_DIM_W'(1) : i_cfg.dst_height;
        // centre of the destination pixel in source units, scaled by 2*dst
        w_px   = {r_col, 1'b1} * w_sw;
        w_py   = {r_row, 1'b1} * w_sh;
        w_nx   = $signed({2'b0, w_px}) - $signed({10'b0, w_dw});
        w_ny   = $signed({2'b0, w_py}) - $signed({10'b0, w_dh});
        w_numx = (w_nx > 0) ? {w_nx[19:0], 16'b0} : '0;
        w_numy = (w_ny > 0) ? {w_ny[19:0], 16'b0} : '0;
    end

    // integer part and Q0.16 fraction from one quotient
    always_comb begin
        w_bxf  = w_qx[CN_W-1:FRAC_W];
        w_byf  = w_qy[CN_W-1:FRAC_W];
        w_swm1 = r_sw - 1'b1;
        w_shm1 = r_sh - 1'b1;
        w_clx  = w_bxf > 20'(w_swm1);
        w_cly  = w_byf > 20'(w_shm1);
        w_bx   = w_clx ? 20'(w_swm1) : w_bxf;
        w_by   = w_cly ? 20'(w_shm1) : w_byf;
    end

    always_comb begin
        case (r_rd_cnt[1:0])
            2'd0:    begin w_rx = r_x0; w_ry = r_y0; end
            2'd1:    begin w_rx = r_x1; w_ry = r_y0; end
            2'd2:    begin w_rx = r_x0; w_ry = r_y1; end
            default: begin w_rx = r_x1; w_ry = r_y1; end
        endcase
        w_raddr  = AW'(32'(w_ry) * MAX_WIDTH + 32'(w_rx));
        w_waddr  = AW'(32'(i_item.row[YW-1:0]) * MAX_WIDTH + 32'(i_item.col[XW-1:0]));
        w_val_we = (r_state == ST_IDLE) && i_item_valid && !i_item.is_cmp && i_item.load_ok;
        w_err_we = w_val_we && i_cfg.use_errors;
    end

    always_comb begin
        case (r_step)
            2'd0:    begin w_av = r_v00; w_bv = r_v01; w_ae = r_e00; w_be = r_e01; w_f = r_fx; end
            2'd1:    begin w_av = r_v10; w_bv = r_v11; w_ae = r_e10; w_be = r_e11; w_f = r_fx; end
            default: begin w_av = r_v0;  w_bv = r_v1;  w_ae = r_e0;  w_be = r_e1;  w_f = r_fy; end
        endcase
        // a + round((b - a) * f), halves toward plus infinity
        w_sumv = r_pv + 51'sd32768;
        w_sume = r_pe + 51'sd32768;
        w_lv   = r_av + w_sumv[47:16];
        w_le   = r_ae + w_sume[47:16];
        w_prv  = r_vres * $signed({1'b0, r_num});
        w_pre  = r_eres * $signed({1'b0, r_num});
        w_magv = r_snv[50] ? 51'(-r_snv) : 51'(r_snv);
        w_mage = r_sne[50] ? 51'(-r_sne) : 51'(r_sne);
        w_satv = fix_sat(w_qv, w_remv != '0, r_vneg);
        w_sate = fix_sat(w_qe, w_reme != '0, r_eneg);
    end

    assign w_start_c = (r_state == ST_MAP);
    assign w_start_s = (r_state == ST_SSTART);

    brir_div #(.NUM_W(CN_W), .DEN_W(CD_W)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start_c),
        .i_num(w_numx), .i_den({w_dw, 1'b0}),
        .o_busy(w_dx_busy), .o_done(w_dx_done), .o_quot(w_qx), .o_rem(w_remx)
    );

    brir_div #(.NUM_W(CN_W), .DEN_W(CD_W)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start_c),
        .i_num(w_numy), .i_den({w_dh, 1'b0}),
        .o_busy(w_dy_busy), .o_done(w_dy_done), .o_quot(w_qy), .o_rem(w_remy)
    );

    brir_div #(.NUM_W(SN_W), .DEN_W(SD_W)) u_div_v (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start_s),
        .i_num({1'b0, w_magv}), .i_den({r_den, 1'b0}),
        .o_busy(w_dv_busy), .o_done(w_dv_done), .o_quot(w_qv), .o_rem(w_remv)
    );

    brir_div #(.NUM_W(SN_W), .DEN_W(SD_W)) u_div_e (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start_s),
        .i_num({1'b0, w_mage}), .i_den({r_den, 1'b0}),
        .o_busy(w_de_busy), .o_done(w_de_done), .o_quot(w_qe), .o_rem(w_reme)
    );

    always_ff @(posedge i_clk) begin
        if (w_val_we) begin
            r_mem_val[w_waddr] <= i_item.value;
        end
        r_vrd <= r_mem_val[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_err_we) begin
            r_mem_err[w_waddr] <= i_item.error;
        end
        r_erd <= r_mem_err[w_raddr];
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_cnt <= '0;
            r_step   <= '0;
            r_ovld   <= 1'b0;
        end else begin
            if (r_ovld && o_rsp.ready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_item_valid && i_item.is_cmp) begin
                        r_state <= ST_MAP;
                    end
                end
                ST_MAP: r_state <= ST_DIV;
                ST_DIV: begin
                    if (w_dx_done && w_dy_done) begin
                        r_state <= ST_IDX;
                    end
                end
                ST_IDX: begin
                    r_rd_cnt <= '0;
                    r_state  <= ST_RD;
                end
                ST_RD: begin
                    r_rd_cnt <= r_rd_cnt + 1'b1;
                    if (r_rd_cnt == 3'd4) begin
                        r_step  <= '0;
                        r_state <= ST_LM;
                    end
                end
                ST_LM: r_state <= ST_LA;
                ST_LA: begin
                    r_step <= r_step + 1'b1;
                    if (r_step != 2'd2) begin
                        r_state <= ST_LM;
                    end else if (i_cfg.keep_total) begin
                        r_state <= ST_SMUL;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_SMUL:   r_state <= ST_SSTART;
                ST_SSTART: r_state <= ST_SDIV;
                ST_SDIV: begin
                    if (w_dv_done && w_de_done) begin
                        r_state <= ST_SFIX;
                    end
                end
                ST_SFIX: r_state <= ST_OUT;
                ST_OUT: begin
                    if (!r_ovld || o_rsp.ready) begin
                        r_ovld  <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_col <= i_item.col;
                r_row <= i_item.row;
            end
            ST_MAP: begin
                r_sw  <= w_sw;
                r_sh  <= w_sh;
                r_num <= w_sw * w_sh;
                r_den <= w_dw * w_dh;
            end
            ST_IDX: begin
                r_x0 <= w_bx[XW-1:0];
                r_y0 <= w_by[YW-1:0];
                r_x1 <= (w_bx < 20'(w_swm1)) ? XW'(w_bx + 1'b1) : XW'(w_swm1);
                r_y1 <= (w_by < 20'(w_shm1)) ? YW'(w_by + 1'b1) : YW'(w_shm1);
                r_fx <= w_clx ? FRAC_ONE : {1'b0, w_qx[FRAC_W-1:0]};
                r_fy <= w_cly ? FRAC_ONE : {1'b0, w_qy[FRAC_W-1:0]};
            end
            ST_RD: begin
                case (r_rd_cnt)
                    3'd1:    begin r_v00 <= r_vrd; r_e00 <= r_erd; end
                    3'd2:    begin r_v01 <= r_vrd; r_e01 <= r_erd; end
                    3'd3:    begin r_v10 <= r_vrd; r_e10 <= r_erd; end
                    3'd4:    begin r_v11 <= r_vrd; r_e11 <= r_erd; end
                    default: ;
                endcase
            end
            ST_LM: begin
                r_av <= w_av;
                r_ae <= w_ae;
                r_pv <= ($signed({w_bv[31], w_bv}) - $signed({w_av[31], w_av}))
                        * $signed({1'b0, w_f});
                r_pe <= ($signed({w_be[31], w_be}) - $signed({w_ae[31], w_ae}))
                        * $signed({1'b0, w_f});
            end
            ST_LA: begin
                case (r_step)
                    2'd0:    begin r_v0 <= w_lv; r_e0 <= w_le; end
                    2'd1:    begin r_v1 <= w_lv; r_e1 <= w_le; end
                    default: begin r_vres <= w_lv; r_eres <= w_le; end
                endcase
            end
            ST_SMUL: begin
                r_snv <= {w_prv[48], w_prv, 1'b0} + {29'b0, r_den};
                r_sne <= {w_pre[48], w_pre, 1'b0} + {29'b0, r_den};
            end
            ST_SSTART: begin
                r_vneg <= r_snv[50];
                r_eneg <= r_sne[50];
            end
            ST_SFIX: begin
                r_vres <= w_satv;
                r_eres <= w_sate;
            end
            ST_OUT: begin
                if (!r_ovld || o_rsp.ready) begin
                    r_oval <= r_vres;
                    r_oerr <= i_cfg.use_errors ? r_eres : '0;
                end
            end
            default: ;
        endcase
    end

    assign o_item_ready     = (r_state == ST_IDLE);
    assign o_rsp.valid      = r_ovld;
    assign o_rsp.out_value  = r_oval;
    assign o_rsp.out_error  = r_oerr;
    assign o_stat.in_out    = (r_state == ST_OUT);
    assign o_stat.divx_busy = w_dx_busy;
    assign o_stat.divy_busy = w_dy_busy;
endmodule

>>> tb/tb_top.sv
// self-checking testbench for the bilinear plane resampler
module tb_top;
    import brir_pkg::*;

    localparam int STORE_W = DEF_MAX_WIDTH;
    localparam int STORE_H = DEF_MAX_HEIGHT;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] error;
    } t_pixel_res;

    class resample_scoreboard;
        logic [VAL_W-1:0]     value_mem[STORE_W*STORE_H];
        logic [VAL_W-1:0]     error_mem[STORE_W*STORE_H];
        logic [SRC_DIM_W-1:0] src_w, src_h;
        logic [DST_DIM_W-1:0] dst_w, dst_h;
        bit                   keep_total, use_errors;
        t_pixel_res           pending_q[$];
        int                   errors, n_loads, n_computes, n_checked;

        function new();
            src_w = 128; src_h = 128; dst_w = 128; dst_h = 128;
            keep_total = 0; use_errors = 0;
        endfunction

        function void report(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $time, msg);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_SRC_WIDTH:  src_w = d[SRC_DIM_W-1:0];
                CFG_SRC_HEIGHT: src_h = d[SRC_DIM_W-1:0];
                CFG_DST_WIDTH:  dst_w = d[DST_DIM_W-1:0];
                CFG_DST_HEIGHT: dst_h = d[DST_DIM_W-1:0];
                CFG_KEEP_TOTAL: keep_total = d[0];
                CFG_USE_ERRORS: use_errors = d[0];
                default: ;
            endcase
        endfunction

        static function longint fdiv(longint n, longint d);
            if (n >= 0) return n / d;
            return -((-n + d - 1) / d);
        endfunction

        static function longint dim_of(longint v, longint hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        static function longint blend(longint a, longint b, longint f);
            return fdiv(a * (65536 - f) + b * f + 32768, 65536);
        endfunction

        static function void axis(longint c, longint s, longint d,
                                  output longint i0, output longint i1,
                                  output longint f);
            longint n, two_d, base, rem;
            n = (2 * c + 1) * s - d;
            two_d = 2 * d;
            base = (n > 0) ? n / two_d : 0;
            if (base > s - 1) base = s - 1;
            i0 = base;
            i1 = (base + 1 > s - 1) ? s - 1 : base + 1;
            rem = n - two_d * base;
            if (rem <= 0) f = 0;
            else if (rem >= two_d) f = 65536;
            else f = (rem * 65536) / two_d;
        endfunction

        function longint sample(bit use_err, longint x0, longint x1, longint y0,
                                longint y1, longint fx, longint fy);
            longint a, b, c, d;
            if (use_err) begin
                a = $signed(error_mem[y0*STORE_W+x0]); b = $signed(error_mem[y0*STORE_W+x1]);
                c = $signed(error_mem[y1*STORE_W+x0]); d = $signed(error_mem[y1*STORE_W+x1]);
            end else begin
                a = $signed(value_mem[y0*STORE_W+x0]); b = $signed(value_mem[y0*STORE_W+x1]);
                c = $signed(value_mem[y1*STORE_W+x0]); d = $signed(value_mem[y1*STORE_W+x1]);
            end
            return blend(blend(a, b, fx), blend(c, d, fx), fy);
        endfunction

        static function longint area_scale(longint v, longint num, longint den);
            longint r;
            r = fdiv(2 * v * num + den, 2 * den);
            if (r > 64'sd2147483647) r = 64'sd2147483647;
            if (r < -64'sd2147483648) r = -64'sd2147483648;
            return r;
        endfunction

        function void note(logic t, logic [COORD_W-1:0] c, logic [COORD_W-1:0] r,
                           logic [VAL_W-1:0] pv, logic [VAL_W-1:0] pe);
            longint sw, sh, dw, dh, x0, x1, y0, y1, fx, fy, v, e;
            t_pixel_res res;
            if (t == REQ_LOAD) begin
                n_loads++;
                if (c < STORE_W && r < STORE_H) begin
                    value_mem[r*STORE_W+c] = pv;
                    if (use_errors) error_mem[r*STORE_W+c] = pe;
                end
                return;
            end
            n_computes++;
            sw = dim_of(src_w, STORE_W); sh = dim_of(src_h, STORE_H);
            dw = dim_of(dst_w, 2047); dh = dim_of(dst_h, 2047);
            axis(c, sw, dw, x0, x1, fx);
            axis(r, sh, dh, y0, y1, fy);
            v = sample(0, x0, x1, y0, y1, fx, fy);
            e = use_errors ? sample(1, x0, x1, y0, y1, fx, fy) : 0;
            if (keep_total) begin
                v = area_scale(v, sw * sh, dw * dh);
                e = area_scale(e, sw * sh, dw * dh);
            end
            res.value = v[31:0];
            res.error = e[31:0];
            pending_q.push_back(res);
        endfunction

        function void check(logic [VAL_W-1:0] v, logic [VAL_W-1:0] e);
            t_pixel_res exp_res;
            n_checked++;
            if (pending_q.size() == 0) begin
                report($sformatf("result with nothing pending: %h %h", v, e));
                return;
            end
            exp_res = pending_q.pop_front();
            if (v !== exp_res.value)
                report($sformatf("out_value %h, predicted %h", v, exp_res.value));
            if (e !== exp_res.error)
                report($sformatf("out_error %h, predicted %h", e, exp_res.error));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    brir_req_if req();
    brir_rsp_if rsp();

    resample_scoreboard sb = new();
    int burst_left = 0;
    int n_phases = 0;
    int cur_w = 128, cur_h = 128;   // effective source size of the current phase
    bit cur_err = 0;

    bilinear_image_resampler DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req.sink),
        .o_rsp      (rsp.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("timeout, %0d results still pending", sb.pending_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // accepted words on both channels
    always @(posedge i_clk) begin
        if (i_rst_n && req.valid && req.ready)
            sb.note(req.req_type, req.col, req.row, req.pixel_value, req.pixel_error);
        if (i_rst_n && rsp.valid && rsp.ready)
            sb.check(rsp.out_value, rsp.out_error);
    end

    // receiver stall pattern: randomly chosen among four modes
    int rx_mode = 0, rx_left = 50;
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 3) != 0);
            2: rsp.ready <= $urandom_range(0, 1);
            default: rsp.ready <= (rx_left % 8 == 0);
        endcase
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d[CFG_DATA_W-1:0];
        @(posedge i_clk);
        sb.set_reg(idx, d[CFG_DATA_W-1:0]);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic send_word(logic t, int c, int r, logic [31:0] pv, logic [31:0] pe);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        req.valid       <= 1'b1;
        req.req_type    <= t;
        req.col         <= c[COORD_W-1:0];
        req.row         <= r[COORD_W-1:0];
        req.pixel_value <= pv;
        req.pixel_error <= pe;
        do @(posedge i_clk); while (!req.ready);
    endtask

    // drain all results, then cover the tail of a load still in flight
    task automatic wait_idle();
        req.valid <= 1'b0;
        burst_left = 0;
        // let the last accepted word be noted first
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'hffffffff;
            4: return $urandom_range(0, 4095) - 2048;
            default: return $urandom;
        endcase
    endfunction

    task automatic fill_region();
        for (int r = 0; r < cur_h; r++)
            for (int c = 0; c < cur_w; c++)
                send_word(REQ_LOAD, c, r, rand_val(), rand_val());
    endtask

    task automatic new_phase();
        int sw, sh, dw, dh, k;
        n_phases++;
        k = $urandom_range(0, 9);
        if (k == 0) begin
            sw = $urandom_range(128, 255); sh = $urandom_range(0, 2);
        end else if (k == 1) begin
            sw = $urandom_range(0, 2); sh = $urandom_range(128, 255);
        end else begin
            sw = $urandom_range(0, 9); sh = $urandom_range(0, 9);
        end
        k = $urandom_range(0, 9);
        dw = (k == 0) ? $urandom_range(1000, 2047) : (k == 1) ? 0 : $urandom_range(1, 24);
        k = $urandom_range(0, 9);
        dh = (k == 0) ? $urandom_range(1000, 2047) : (k == 1) ? 0 : $urandom_range(1, 24);
        cur_err = $urandom_range(0, 1);
        write_reg(CFG_SRC_WIDTH, sw);
        write_reg(CFG_SRC_HEIGHT, sh);
        write_reg(CFG_DST_WIDTH, dw);
        write_reg(CFG_DST_HEIGHT, dh);
        write_reg(CFG_KEEP_TOTAL, $urandom_range(0, 1));
        write_reg(CFG_USE_ERRORS, cur_err);
        cur_w = (sw == 0) ? 1 : (sw > 128) ? 128 : sw;
        cur_h = (sh == 0) ? 1 : (sh > 128) ? 128 : sh;
        fill_region();
    endtask

    initial begin
        int c, r, k, n;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        req.valid = 1'b0; req.req_type = REQ_LOAD; req.col = '0; req.row = '0;
        req.pixel_value = '0; req.pixel_error = '0;
        rsp.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: 2x2 source of extreme values blown up to 3x3
        write_reg(CFG_SRC_WIDTH, 2);
        write_reg(CFG_SRC_HEIGHT, 2);
        write_reg(CFG_DST_WIDTH, 3);
        write_reg(CFG_DST_HEIGHT, 3);
        write_reg(CFG_USE_ERRORS, 1);
        send_word(REQ_LOAD, 0, 0, 32'h7fffffff, 32'h80000000);
        send_word(REQ_LOAD, 1, 0, 32'h80000000, 32'h7fffffff);
        send_word(REQ_LOAD, 0, 1, 32'h0, 32'hffffffff);
        send_word(REQ_LOAD, 1, 1, 32'hffffffff, 32'h00000001);
        // loads outside the store are dropped
        send_word(REQ_LOAD, 128, 0, 32'h12345678, 32'h1);
        send_word(REQ_LOAD, 0, 1023, 32'h12345678, 32'h1);
        send_word(REQ_COMPUTE, 0, 0, 32'hffffffff, 32'hffffffff);
        send_word(REQ_COMPUTE, 1, 1, 0, 0);
        send_word(REQ_COMPUTE, 2, 2, 0, 0);
        // outside the destination, clamped to the source edge
        send_word(REQ_COMPUTE, 1023, 1023, 0, 0);
        send_word(REQ_COMPUTE, 512, 0, 0, 0);
        wait_idle();
        // load with errors off leaves the error store alone
        write_reg(CFG_USE_ERRORS, 0);
        send_word(REQ_LOAD, 0, 0, 32'h00000100, 32'h55555555);
        send_word(REQ_COMPUTE, 0, 0, 0, 0);
        wait_idle();
        write_reg(CFG_USE_ERRORS, 1);
        send_word(REQ_COMPUTE, 0, 0, 0, 0);
        wait_idle();
        // area scaling by four saturates both ways
        write_reg(CFG_DST_WIDTH, 1);
        write_reg(CFG_DST_HEIGHT, 1);
        write_reg(CFG_KEEP_TOTAL, 1);
        send_word(REQ_COMPUTE, 0, 0, 0, 0);
        send_word(REQ_COMPUTE, 5, 0, 0, 0);
        wait_idle();
        write_reg(CFG_DST_WIDTH, 1024);
        write_reg(CFG_DST_HEIGHT, 1024);
        send_word(REQ_COMPUTE, 1023, 0, 0, 0);
        send_word(REQ_COMPUTE, 0, 1023, 0, 0);
        wait_idle();

        // random phases: fill the source, then mixed traffic
        while (sb.n_loads + sb.n_computes < 1300) begin
            new_phase();
            n = $urandom_range(20, 60);
            for (int i = 0; i < n; i++) begin
                k = $urandom_range(0, 9);
                if (k < 7) begin
                    case ($urandom_range(0, 3))
                        0: begin c = $urandom_range(0, 1023); r = $urandom_range(0, 1023); end
                        default: begin c = $urandom_range(0, 30); r = $urandom_range(0, 30); end
                    endcase
                    send_word(REQ_COMPUTE, c, r, $urandom, $urandom);
                end else if (k < 9) begin
                    send_word(REQ_LOAD, $urandom_range(0, cur_w - 1),
                              $urandom_range(0, cur_h - 1), rand_val(), rand_val());
                end else begin
                    send_word(REQ_LOAD, $urandom_range(0, 1023), $urandom_range(0, 1023),
                              rand_val(), rand_val());
                end
            end
            wait_idle();
        end

        $display("covered %0d loads and %0d computes over %0d register settings",
                 sb.n_loads, sb.n_computes, n_phases);
        $display("%0d results checked, %0d mismatches", sb.n_checked, sb.errors);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
